### rtl/lpfr_pkg.sv
// Shared types and constants of the length-prefixed frame receiver.
// Used by the channel interfaces and the top level; depends on nothing.
package lpfr_pkg;

  // Payload widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CMD_ID_W  = 5;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned CFG_IDX_W = 8;
  // Frame counters span a size byte plus the fixed overhead
  localparam int unsigned CNT_W     = 9;

  // Command byte plus two checksum bytes follow the size byte
  localparam logic [CNT_W-1:0] SIZE_OVERHEAD = 9'd3;
  // Code byte plus two checksum bytes of an error frame
  localparam logic [CNT_W-1:0] ERROR_LEN     = 9'd3;
  // Start, size, command and two checksum bytes around the payload
  localparam logic [CNT_W-1:0] FRAME_EXTRA   = 9'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_CODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_CODE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_CODE    = 8'd2;

  // Reset values of the start codes
  localparam logic [BYTE_W-1:0] RST_REQUEST_CODE  = 8'd1;
  localparam logic [BYTE_W-1:0] RST_RESPONSE_CODE = 8'd2;
  localparam logic [BYTE_W-1:0] RST_ERROR_CODE    = 8'd3;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_RESPONSE = 2'd2,
    KIND_ERROR    = 2'd3
  } frame_kind_t;

  typedef enum logic [3:0] {
    S_START  = 4'b0001,
    S_SIZE   = 4'b0010,
    S_DATA   = 4'b0100,
    S_REPLAY = 4'b1000
  } state_t;

endpackage

### rtl/lpfr_in_if.sv
// Received-byte channel of the frame receiver.
// Depends on lpfr_pkg for the byte width.
interface lpfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [lpfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/lpfr_out_if.sv
// Dispatched-request channel of the frame receiver, one payload byte per request.
// Depends on lpfr_pkg for the field widths.
interface lpfr_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpfr_pkg::CMD_ID_W-1:0] command_id;
  logic [lpfr_pkg::BYTE_W-1:0]   payload_byte;
  logic                          has_payload;
  logic [lpfr_pkg::COUNT_W-1:0]  payload_count;
  logic                          last;

  modport source (output valid, output command_id, output payload_byte,
                  output has_payload, output payload_count, output last, input ready);
  modport sink   (input valid, input command_id, input payload_byte,
                  input has_payload, input payload_count, input last, output ready);
endinterface

### rtl/lpfr_cfg_if.sv
// Register write channel of the frame receiver.
// Depends on lpfr_pkg for the index and data widths.
interface lpfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lpfr_pkg::CFG_IDX_W-1:0] index;
  logic [lpfr_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/length_prefixed_frame_receiver_top.sv
// Length-prefixed frame receiver: takes one serial byte per request and
// parses request, response and error frames framed by configurable start
// codes. While a frame is received, one byte is taken every cycle. When a
// request frame with a command below COMMAND_SLOTS ends, the input is held
// off while its payload is replayed from the frame memory, one byte per
// request on the output; the single read port of that memory is read one entry
// ahead of the output register, an empty payload gives a single request with no
// payload, and the replay pauses while the sink stalls. Oversized frames
// (size + 5 above BUFFER_DEPTH), response and error frames are consumed
// without output. Checksums are not checked.
// Depends on lpfr_pkg and the lpfr_in_if, lpfr_out_if and lpfr_cfg_if interfaces.
module length_prefixed_frame_receiver_top #(
  parameter int unsigned BUFFER_DEPTH  = 64,
  parameter int unsigned COMMAND_SLOTS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  lpfr_in_if.sink          in_ch,
  lpfr_out_if.source       out_ch,
  lpfr_cfg_if.sink         cfg_ch
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [lpfr_pkg::CNT_W-1:0] DEPTH_C = lpfr_pkg::CNT_W'(BUFFER_DEPTH);
  localparam logic [lpfr_pkg::CNT_W-1:0] SLOTS_C = lpfr_pkg::CNT_W'(COMMAND_SLOTS);

  // Start codes
  logic [lpfr_pkg::BYTE_W-1:0] req_code_r, rsp_code_r, err_code_r;

  // Frame parser state
  lpfr_pkg::state_t            state_r, state_nxt;
  lpfr_pkg::frame_kind_t       kind_r, kind_nxt;
  logic [lpfr_pkg::CNT_W-1:0]  remaining_r, remaining_nxt;
  logic [lpfr_pkg::CNT_W-1:0]  received_r, received_nxt;
  logic [lpfr_pkg::BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [lpfr_pkg::BYTE_W-1:0] size_r, size_nxt;
  logic                        ovf_r, ovf_nxt;

  // Replay sequencer
  logic [AW-1:0]               rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]               ld_idx_r, ld_idx_nxt;
  logic                        rd_pend_r, rd_pend_nxt;

  // Frame memory
  logic [lpfr_pkg::BYTE_W-1:0] frame_mem [BUFFER_DEPTH];
  logic [lpfr_pkg::BYTE_W-1:0] mem_q_r;
  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr;

  // Output register
  logic                          out_valid_r;
  logic [lpfr_pkg::CMD_ID_W-1:0] out_cmd_r;
  logic [lpfr_pkg::BYTE_W-1:0]   out_byte_r;
  logic                          out_has_r;
  logic [lpfr_pkg::COUNT_W-1:0]  out_cnt_r;
  logic                          out_last_r;
  logic                          load;
  logic                          load_last;

  logic                          in_acc;
  logic                          out_free;
  logic [lpfr_pkg::BYTE_W-1:0]   b;
  logic [lpfr_pkg::CNT_W-1:0]    b_ext;
  logic [lpfr_pkg::CNT_W-1:0]    size_ext;
  logic                          size_zero;

  assign b         = in_ch.rx_byte;
  assign b_ext     = {1'b0, b};
  assign size_ext  = {1'b0, size_r};
  assign size_zero = (size_r == '0);
  assign in_ch.ready  = (state_r != lpfr_pkg::S_REPLAY);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign wr_addr      = AW'(received_r - 9'd1);
  assign load_last    = size_zero ||
                        ((lpfr_pkg::CNT_W'(ld_idx_r) + 9'd1) == size_ext);

  // Write start codes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_code_r <= lpfr_pkg::RST_REQUEST_CODE;
      rsp_code_r <= lpfr_pkg::RST_RESPONSE_CODE;
      err_code_r <= lpfr_pkg::RST_ERROR_CODE;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        lpfr_pkg::REG_REQUEST_CODE:  req_code_r <= cfg_ch.data;
        lpfr_pkg::REG_RESPONSE_CODE: rsp_code_r <= cfg_ch.data;
        lpfr_pkg::REG_ERROR_CODE:    err_code_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Parse frames and sequence the payload replay
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    remaining_nxt = remaining_r;
    received_nxt  = received_r;
    cmd_nxt       = cmd_r;
    size_nxt      = size_r;
    ovf_nxt       = ovf_r;
    rd_idx_nxt    = rd_idx_r;
    ld_idx_nxt    = ld_idx_r;
    rd_pend_nxt   = rd_pend_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    load          = 1'b0;
    case (state_r)
      lpfr_pkg::S_START: begin
        if (in_acc) begin
          // request code wins over response, response over error
          if (b == req_code_r) begin
            kind_nxt  = lpfr_pkg::KIND_REQUEST;
            state_nxt = lpfr_pkg::S_SIZE;
          end else if (b == rsp_code_r) begin
            kind_nxt  = lpfr_pkg::KIND_RESPONSE;
            state_nxt = lpfr_pkg::S_SIZE;
          end else if (b == err_code_r) begin
            kind_nxt      = lpfr_pkg::KIND_ERROR;
            state_nxt     = lpfr_pkg::S_DATA;
            remaining_nxt = lpfr_pkg::ERROR_LEN;
            received_nxt  = '0;
            ovf_nxt       = 1'b0;
          end
        end
      end
      lpfr_pkg::S_SIZE: begin
        if (in_acc) begin
          size_nxt      = b;
          remaining_nxt = b_ext + lpfr_pkg::SIZE_OVERHEAD;
          received_nxt  = '0;
          ovf_nxt       = (b_ext + lpfr_pkg::FRAME_EXTRA) > DEPTH_C;
          state_nxt     = lpfr_pkg::S_DATA;
        end
      end
      lpfr_pkg::S_DATA: begin
        if (in_acc) begin
          // first byte is the command or error code, then payload
          if (received_r == '0) begin
            cmd_nxt = b;
          end
          wr_en = (received_r != '0) && (kind_r != lpfr_pkg::KIND_ERROR) &&
                  (received_r <= size_ext) && !ovf_r;
          received_nxt = received_r + 9'd1;
          if (remaining_r != '0) begin
            remaining_nxt = remaining_r - 9'd1;
          end
          if (remaining_r <= 9'd1) begin
            if (kind_r == lpfr_pkg::KIND_REQUEST && !ovf_r &&
                ({1'b0, cmd_r} < SLOTS_C)) begin
              state_nxt = lpfr_pkg::S_REPLAY;
            end else begin
              state_nxt = lpfr_pkg::S_START;
            end
            kind_nxt      = lpfr_pkg::KIND_NONE;
            remaining_nxt = '0;
            received_nxt  = '0;
            ovf_nxt       = 1'b0;
            rd_idx_nxt    = '0;
            ld_idx_nxt    = '0;
            rd_pend_nxt   = 1'b0;
          end
        end
      end
      lpfr_pkg::S_REPLAY: begin
        if (size_zero) begin
          load = out_free;
        end else begin
          // read one entry ahead; hold the read data until it is loaded
          load  = rd_pend_r && out_free;
          rd_en = (lpfr_pkg::CNT_W'(rd_idx_r) < size_ext) && (!rd_pend_r || load);
          if (rd_en) begin
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
          rd_pend_nxt = rd_en || (rd_pend_r && !load);
          if (load) begin
            ld_idx_nxt = ld_idx_r + AW'(1);
          end
        end
        if (load && load_last) begin
          state_nxt = lpfr_pkg::S_START;
        end
      end
      default: begin
        state_nxt = lpfr_pkg::S_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpfr_pkg::S_START;
      kind_r      <= lpfr_pkg::KIND_NONE;
      remaining_r <= '0;
      received_r  <= '0;
      cmd_r       <= '0;
      size_r      <= '0;
      ovf_r       <= 1'b0;
      rd_idx_r    <= '0;
      ld_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      remaining_r <= remaining_nxt;
      received_r  <= received_nxt;
      cmd_r       <= cmd_nxt;
      size_r      <= size_nxt;
      ovf_r       <= ovf_nxt;
      rd_idx_r    <= rd_idx_nxt;
      ld_idx_r    <= ld_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  // Frame memory: written while receiving, read only during replay,
  // so the two ports never touch the same entry in one cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= b;
    end
    if (rd_en) begin
      mem_q_r <= frame_mem[rd_idx_r];
    end
  end

  // Output register: load a request, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture command and count too, so a waiting request holds while the next frame arrives
  always_ff @(posedge clk) begin
    if (load) begin
      out_cmd_r  <= cmd_r[lpfr_pkg::CMD_ID_W-1:0];
      out_byte_r <= size_zero ? '0 : mem_q_r;
      out_has_r  <= !size_zero;
      out_cnt_r  <= size_r[lpfr_pkg::COUNT_W-1:0];
      out_last_r <= load_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.command_id    = out_cmd_r;
  assign out_ch.payload_byte  = out_byte_r;
  assign out_ch.has_payload   = out_has_r;
  assign out_ch.payload_count = out_cnt_r;
  assign out_ch.last          = out_last_r;

`ifndef SYNTH
  // An empty-payload request is always the final one of its frame
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_has_r |-> out_last_r)
    else $error("empty-payload request without last");

  // The memory is read only while replaying a frame
  a_read_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> state_r == lpfr_pkg::S_REPLAY)
    else $error("frame memory read outside replay");

  // The memory is written only while receiving frame data
  a_write_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == lpfr_pkg::S_DATA && in_acc)
    else $error("frame memory write outside data phase");

  // Loading the final request of a frame ends the replay
  a_last_ends_replay: assert property (@(posedge clk) disable iff (!rst_n)
    load && load_last |=> state_r == lpfr_pkg::S_START)
    else $error("replay did not end after last request");

  // Pending read data exists only during a non-empty replay
  a_pend_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> state_r == lpfr_pkg::S_REPLAY && !size_zero)
    else $error("read pending outside replay");
`endif

endmodule

### tb/sv/length_prefixed_frame_receiver_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the length-prefixed frame receiver: drives framed byte streams
// under several start-code settings and checks every dispatched payload request.
// Depends on lpfr_pkg, the lpfr channel interfaces and length_prefixed_frame_receiver_top.
module length_prefixed_frame_receiver_top_tb;

  localparam int unsigned BYTE_W    = lpfr_pkg::BYTE_W;
  localparam int unsigned CMD_ID_W  = lpfr_pkg::CMD_ID_W;
  localparam int unsigned COUNT_W   = lpfr_pkg::COUNT_W;
  localparam int unsigned CFG_IDX_W = lpfr_pkg::CFG_IDX_W;
  localparam int unsigned CNT_W     = lpfr_pkg::CNT_W;

  localparam int unsigned BUF_DEPTH     = 64;
  localparam int unsigned BUF_AW        = $clog2(BUF_DEPTH);
  localparam int unsigned CMD_SLOTS     = 32;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 400;
  // Indexes past the last register, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

  typedef struct packed {
    logic [CMD_ID_W-1:0] command_id;
    logic [BYTE_W-1:0]   payload_byte;
    logic                has_payload;
    logic [COUNT_W-1:0]  payload_count;
    logic                last;
  } dispatch_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lpfr_in_if  in_ch ();
  lpfr_out_if out_ch ();
  lpfr_cfg_if cfg_ch ();

  length_prefixed_frame_receiver_top #(
    .BUFFER_DEPTH (BUF_DEPTH),
    .COMMAND_SLOTS(CMD_SLOTS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Pending received bytes and the dispatched payload requests still owed
  logic [BYTE_W-1:0] rx_bytes_q [$];
  dispatch_t         dispatch_q [$];

  // Parser state mirrored by the bench
  logic [BYTE_W-1:0]     req_code    = lpfr_pkg::RST_REQUEST_CODE;
  logic [BYTE_W-1:0]     rsp_code    = lpfr_pkg::RST_RESPONSE_CODE;
  logic [BYTE_W-1:0]     err_code    = lpfr_pkg::RST_ERROR_CODE;
  lpfr_pkg::state_t      parse_state = lpfr_pkg::S_START;
  lpfr_pkg::frame_kind_t cur_kind    = lpfr_pkg::KIND_NONE;
  logic [CNT_W-1:0]      bytes_left  = '0;
  logic [CNT_W-1:0]      bytes_seen  = '0;
  logic [BYTE_W-1:0]     cmd_byte    = '0;
  logic [BYTE_W-1:0]     size_byte   = '0;
  logic                  too_long    = 1'b0;
  logic [BYTE_W-1:0]     payload_mem [BUF_DEPTH];

  bit in_accepted = 1'b0;
  bit quiet       = 1'b0;
  bit hold_go     = 1'b0;
  bit rx_hold     = 1'b0;
  int gap_left    = 0;
  int stall_left  = 0;
  int fail_cnt        = 0;
  int frames_sent     = 0;
  int bytes_queued    = 0;
  int bytes_taken     = 0;
  int results_checked = 0;
  int cfg_writes      = 0;

  // Clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the parser by one received byte and queue any payload requests it releases
  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    dispatch_t        r;
    logic [CNT_W-1:0] pos;
    case (parse_state)
      lpfr_pkg::S_START: begin
        if (b == req_code || b == rsp_code) begin
          cur_kind    = (b == req_code) ? lpfr_pkg::KIND_REQUEST : lpfr_pkg::KIND_RESPONSE;
          parse_state = lpfr_pkg::S_SIZE;
        end else if (b == err_code) begin
          cur_kind    = lpfr_pkg::KIND_ERROR;
          parse_state = lpfr_pkg::S_DATA;
          bytes_left  = lpfr_pkg::ERROR_LEN;
          bytes_seen  = '0;
          too_long    = 1'b0;
        end
      end
      lpfr_pkg::S_SIZE: begin
        size_byte   = b;
        bytes_left  = {1'b0, b} + lpfr_pkg::SIZE_OVERHEAD;
        bytes_seen  = '0;
        too_long    = ({1'b0, b} + lpfr_pkg::FRAME_EXTRA) > BUF_DEPTH;
        parse_state = lpfr_pkg::S_DATA;
      end
      default: begin
        pos = bytes_seen;
        if (pos == '0) begin
          cmd_byte = b;
        end else if (cur_kind != lpfr_pkg::KIND_ERROR && pos <= size_byte && !too_long) begin
          payload_mem[BUF_AW'(pos - 9'd1)] = b;
        end
        bytes_seen = bytes_seen + 9'd1;
        if (bytes_left != '0) bytes_left = bytes_left - 9'd1;
        if (bytes_left == '0) begin
          // Release the payload of an accepted request, one request per byte (one empty request if none)
          if (cur_kind == lpfr_pkg::KIND_REQUEST && !too_long && cmd_byte < CMD_SLOTS) begin
            if (size_byte == '0) begin
              r.command_id    = cmd_byte[CMD_ID_W-1:0];
              r.payload_byte  = '0;
              r.has_payload   = 1'b0;
              r.payload_count = '0;
              r.last          = 1'b1;
              dispatch_q.push_back(r);
            end else begin
              for (int i = 0; i < size_byte; i++) begin
                r.command_id    = cmd_byte[CMD_ID_W-1:0];
                r.payload_byte  = payload_mem[BUF_AW'(i)];
                r.has_payload   = 1'b1;
                r.payload_count = size_byte[COUNT_W-1:0];
                r.last          = (i + 1 == size_byte);
                dispatch_q.push_back(r);
              end
            end
          end
          parse_state = lpfr_pkg::S_START;
          cur_kind    = lpfr_pkg::KIND_NONE;
          bytes_left  = '0;
          bytes_seen  = '0;
          too_long    = 1'b0;
        end
      end
    endcase
  endtask

  // Sample both channels at the rising edge: take input requests, check output requests
  always @(posedge clk) begin : monitor
    dispatch_t want;
    in_accepted = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        parse_rx_byte(in_ch.rx_byte);
        void'(rx_bytes_q.pop_front());
        in_accepted = 1'b1;
        bytes_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (dispatch_q.size() == 0) begin
          $error("unexpected result: command_id %0d payload_byte %0d last %0b",
                 out_ch.command_id, out_ch.payload_byte, out_ch.last);
          fail_cnt++;
        end else begin
          want = dispatch_q.pop_front();
          results_checked++;
          if (out_ch.command_id !== want.command_id) begin
            $error("command_id: expected %0d, got %0d", want.command_id, out_ch.command_id);
            fail_cnt++;
          end
          if (out_ch.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0d, got %0d", want.payload_byte,
                   out_ch.payload_byte);
            fail_cnt++;
          end
          if (out_ch.has_payload !== want.has_payload) begin
            $error("has_payload: expected %0d, got %0d", want.has_payload, out_ch.has_payload);
            fail_cnt++;
          end
          if (out_ch.payload_count !== want.payload_count) begin
            $error("payload_count: expected %0d, got %0d", want.payload_count,
                   out_ch.payload_count);
            fail_cnt++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Offer the next pending byte; hold an offer until it is taken, idle in random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (rx_bytes_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 9);
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= rx_bytes_q[0];
      end
    end
  end

  // Drive output ready with random stall bursts and the long hold-off
  always @(negedge clk) begin
    if (rx_hold) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Hold off the output for a long stretch once asked, so the block backs up its input
  initial begin
    wait (hold_go);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Queue one byte for the driver
  task automatic push_rx(input logic [BYTE_W-1:0] val);
    rx_bytes_q.push_back(val);
    bytes_queued++;
  endtask

  // Write one register through the configuration channel
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == lpfr_pkg::REG_REQUEST_CODE) begin
      req_code = val;
    end else if (idx == lpfr_pkg::REG_RESPONSE_CODE) begin
      rsp_code = val;
    end else if (idx == lpfr_pkg::REG_ERROR_CODE) begin
      err_code = val;
    end
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Queue a request or response frame; fill < 0 gives random payload bytes
  task automatic push_sized_frame(input logic [BYTE_W-1:0] start, input int size,
                                  input logic [BYTE_W-1:0] cmd, input int fill);
    push_rx(start);
    push_rx(8'(size));
    push_rx(cmd);
    for (int i = 0; i < size; i++) begin
      push_rx((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
    end
    push_rx(8'($urandom_range(0, 255)));
    push_rx(8'($urandom_range(0, 255)));
    frames_sent++;
  endtask

  // Queue an error frame: start, code and two checksum bytes
  task automatic push_error_frame(input logic [BYTE_W-1:0] code);
    push_rx(err_code);
    push_rx(code);
    push_rx(8'($urandom_range(0, 255)));
    push_rx(8'($urandom_range(0, 255)));
    frames_sent++;
  endtask

  // Mostly short payloads, some around the buffer limit, a few oversized
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 90) return $urandom_range(7, 24);
    if (r < 97) return $urandom_range(56, 61);
    return $urandom_range(62, 70);
  endfunction

  // Queue random traffic: mostly well-formed frames, some stray bytes
  task automatic gen_traffic(input int budget);
    int base;
    int r;
    base = bytes_queued;
    while (bytes_queued - base < budget) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        push_sized_frame(req_code, pick_size(), 8'($urandom_range(0, CMD_SLOTS - 1)), -1);
      end else if (r < 60) begin
        push_sized_frame(req_code, pick_size(), 8'($urandom_range(CMD_SLOTS, 255)), -1);
      end else if (r < 72) begin
        push_sized_frame(rsp_code, pick_size(), 8'($urandom_range(0, 255)), -1);
      end else if (r < 82) begin
        push_error_frame(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) push_rx(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Close any open frame, wait for every owed result, then let the block go idle
  task automatic finish_phase();
    logic [BYTE_W-1:0] filler;
    int                waited;
    filler = '0;
    while (filler == req_code || filler == rsp_code || filler == err_code) filler++;
    while (parse_state != lpfr_pkg::S_START || rx_bytes_q.size() != 0) begin
      if (rx_bytes_q.size() == 0) push_rx(filler);
      @(negedge clk);
    end
    waited = 0;
    while ((in_ch.valid || dispatch_q.size() != 0) && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (dispatch_q.size() != 0) begin
      $error("%0d expected results never arrived", dispatch_q.size());
      fail_cnt++;
      dispatch_q.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: stray extremes, empty and one-byte requests, response, error, bad command
    push_rx(8'h00);
    push_rx(8'hFF);
    push_sized_frame(req_code, 0, 8'd0, -1);
    push_sized_frame(req_code, 1, 8'(CMD_SLOTS - 1), 8'hFF);
    push_sized_frame(rsp_code, 0, 8'd5, -1);
    push_error_frame(8'd7);
    push_sized_frame(req_code, 0, 8'(CMD_SLOTS), -1);
    finish_phase();

    // Extreme codes; hold the output off while a full and an oversized frame arrive
    write_reg(lpfr_pkg::REG_REQUEST_CODE, 8'h00);
    write_reg(lpfr_pkg::REG_RESPONSE_CODE, 8'hFF);
    write_reg(lpfr_pkg::REG_ERROR_CODE, 8'h80);
    hold_go = 1'b1;
    push_sized_frame(req_code, BUF_DEPTH - lpfr_pkg::FRAME_EXTRA,
                     8'($urandom_range(0, 31)), -1);
    push_sized_frame(req_code, BUF_DEPTH - lpfr_pkg::FRAME_EXTRA + 1,
                     8'($urandom_range(0, 31)), -1);
    gen_traffic(10);
    finish_phase();

    // All three codes equal: request wins; stray indexes must be ignored
    write_reg(lpfr_pkg::REG_REQUEST_CODE, 8'h5A);
    write_reg(lpfr_pkg::REG_RESPONSE_CODE, 8'h5A);
    write_reg(lpfr_pkg::REG_ERROR_CODE, 8'h5A);
    write_reg(REG_UNUSED_LOW, 8'h11);
    write_reg(REG_UNUSED_HIGH, 8'h22);
    gen_traffic(25);
    finish_phase();

    // Response and error share a code: response wins
    write_reg(lpfr_pkg::REG_REQUEST_CODE, 8'hFF);
    write_reg(lpfr_pkg::REG_RESPONSE_CODE, 8'h00);
    write_reg(lpfr_pkg::REG_ERROR_CODE, 8'h00);
    gen_traffic(25);
    finish_phase();

    // Reset codes, full rate on both sides
    write_reg(lpfr_pkg::REG_REQUEST_CODE, lpfr_pkg::RST_REQUEST_CODE);
    write_reg(lpfr_pkg::REG_RESPONSE_CODE, lpfr_pkg::RST_RESPONSE_CODE);
    write_reg(lpfr_pkg::REG_ERROR_CODE, lpfr_pkg::RST_ERROR_CODE);
    quiet = 1'b1;
    gen_traffic(35);
    finish_phase();

    $display("Sent %0d frames in %0d received bytes under five start-code settings,",
             frames_sent, bytes_taken);
    $display("with %0d reg writes; checked %0d dispatched payload results field by field.",
             cfg_writes, results_checked);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lpfr_pkg.sv
rtl/lpfr_in_if.sv
rtl/lpfr_out_if.sv
rtl/lpfr_cfg_if.sv
rtl/length_prefixed_frame_receiver_top.sv
tb/sv/length_prefixed_frame_receiver_top_tb.sv
